// ===== rtl/pesd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesd_pkg
// Shared types and constants for the pose error steering decision block.
// ----------------------------------------------------------------------------
package pesd_pkg;

    localparam int ANGLE_W    = 16;
    localparam int CORDIC_Z_W = 32;
    localparam int ATAN_LEN   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int TOL_W      = 15;
    localparam int ARRIVE_W   = 19;
    localparam int FRAC_BITS  = 8;
    localparam int INV_GAIN   = 636752;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X       = 3'd0,
        REG_ORIGIN_Y       = 3'd1,
        REG_ORIGIN_HEADING = 3'd2,
        REG_HEADING_TOL    = 3'd3,
        REG_ARRIVE_TOL     = 3'd4,
        REG_DRIVE_SPEED    = 3'd5,
        REG_TURN_RATE      = 3'd6
    } cfg_index_t;

    // atan(2^-i) with 2^32 = 2 pi, rounded to nearest
    function automatic logic [CORDIC_Z_W-1:0] atan_entry(input int i);
        logic [CORDIC_Z_W-1:0] v;
        begin
            case (i)
                0:       v = 32'd536870912;
                1:       v = 32'd316933406;
                2:       v = 32'd167458907;
                3:       v = 32'd85004756;
                4:       v = 32'd42667331;
                5:       v = 32'd21354465;
                6:       v = 32'd10679838;
                7:       v = 32'd5340245;
                8:       v = 32'd2670163;
                9:       v = 32'd1335087;
                10:      v = 32'd667544;
                11:      v = 32'd333772;
                12:      v = 32'd166886;
                13:      v = 32'd83443;
                14:      v = 32'd41722;
                15:      v = 32'd20861;
                16:      v = 32'd10430;
                17:      v = 32'd5215;
                18:      v = 32'd2608;
                19:      v = 32'd1304;
                20:      v = 32'd652;
                21:      v = 32'd326;
                22:      v = 32'd163;
                23:      v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/pesd_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesd_cordic_cell
// One registered CORDIC micro-rotation, rotating or vectoring, with a side word
// that travels alongside the vector.
// ----------------------------------------------------------------------------
module pesd_cordic_cell #(
    parameter int W         = 31,
    parameter int SW        = 56,
    parameter int STAGE     = 0,
    parameter bit VECTORING = 1'b0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [W-1:0]                    x_in,
    input  logic signed [W-1:0]                    y_in,
    input  logic        [pesd_pkg::CORDIC_Z_W-1:0] z_in,
    input  logic        [SW-1:0]                   side_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [W-1:0]                    x_out,
    output logic signed [W-1:0]                    y_out,
    output logic        [pesd_pkg::CORDIC_Z_W-1:0] z_out,
    output logic        [SW-1:0]                   side_out
);
    import pesd_pkg::*;

    localparam logic [CORDIC_Z_W-1:0] ANGLE = atan_entry(STAGE);

    logic                  valid_reg;
    logic signed [W-1:0]   x_reg, x_next;
    logic signed [W-1:0]   y_reg, y_next;
    logic [CORDIC_Z_W-1:0] z_reg, z_next;
    logic [SW-1:0]         side_reg;
    logic signed [W-1:0]   dx, dy;
    logic                  sigma_pos;
    logic                  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        dx        = y_in >>> STAGE;
        dy        = x_in >>> STAGE;
        sigma_pos = VECTORING ? y_in[W-1] : !z_in[CORDIC_Z_W-1];
        if (sigma_pos)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

// ===== rtl/pose_error_steering_decision_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_error_steering_decision_top
// Pose error to steering command: frame rotation, bearing, forward or reverse.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is accepted every cycle while the output is not
// stalled, and its result passes through the two rows of CORDIC cells (frame
// rotation, then bearing), the gain multiply, the rounding stage and the
// decision register. Each stage holds its word while downstream stalls and
// takes a new one as soon as it is free. Configuration writes are always
// taken.
module pose_error_steering_decision_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int POS_WIDTH     = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [POS_WIDTH-1:0]  pos_x,
    input  logic signed [POS_WIDTH-1:0]  pos_y,
    input  logic signed [15:0]           heading,
    input  logic signed [POS_WIDTH-1:0]  goal_dx,
    input  logic signed [POS_WIDTH-1:0]  goal_dy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           drive_cmd,
    output logic signed [15:0]           turn_cmd,
    output logic                         reversing,
    output logic                         arrived,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pesd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((POS_WIDTH > 19) ? POS_WIDTH : 19)-1:0] cfg_data
);
    import pesd_pkg::*;

    localparam int NR   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int PW   = POS_WIDTH;
    localparam int RW   = PW + 11;
    localparam int GW   = RW + 21;
    localparam int VXW  = PW + 4;
    localparam int VW   = PW + 14;
    localparam int AW   = (VXW > ARRIVE_W) ? VXW : ARRIVE_W;
    localparam int RSW  = 2 * PW + ANGLE_W;
    localparam int VSW  = 2 * ANGLE_W + 2;

    // configuration
    logic signed [PW-1:0]      origin_x_reg;
    logic signed [PW-1:0]      origin_y_reg;
    logic [ANGLE_W-1:0]        origin_heading_reg;
    logic [TOL_W-1:0]          heading_tol_reg;
    logic [ARRIVE_W-1:0]       arrive_tol_reg;
    logic [TOL_W-1:0]          drive_speed_reg;
    logic [TOL_W-1:0]          turn_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            origin_heading_reg <= '0;
            heading_tol_reg    <= 15'd546;
            arrive_tol_reg     <= 19'd80;
            drive_speed_reg    <= 15'd50;
            turn_rate_reg      <= 15'd819;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X:       origin_x_reg       <= cfg_data[PW-1:0];
                REG_ORIGIN_Y:       origin_y_reg       <= cfg_data[PW-1:0];
                REG_ORIGIN_HEADING: origin_heading_reg <= cfg_data[ANGLE_W-1:0];
                REG_HEADING_TOL:    heading_tol_reg    <= cfg_data[TOL_W-1:0];
                REG_ARRIVE_TOL:     arrive_tol_reg     <= cfg_data[ARRIVE_W-1:0];
                REG_DRIVE_SPEED:    drive_speed_reg    <= cfg_data[TOL_W-1:0];
                REG_TURN_RATE:      turn_rate_reg      <= cfg_data[TOL_W-1:0];
                default:            ;
            endcase
        end
    end

    // rotation row
    logic                  rv   [0:NR];
    logic                  rrdy [0:NR];
    logic signed [RW-1:0]  rx   [0:NR];
    logic signed [RW-1:0]  ry   [0:NR];
    logic [CORDIC_Z_W-1:0] rz   [0:NR];
    logic [RSW-1:0]        rs   [0:NR];

    logic signed [PW:0]    ex, ey;
    logic [ANGLE_W-1:0]    detw;
    logic [CORDIC_Z_W-1:0] rot_a;
    logic                  flip;
    logic signed [RW-1:0]  xs, ys;

    always_comb
    begin
        ex    = {pos_x[PW-1], pos_x} - {origin_x_reg[PW-1], origin_x_reg};
        ey    = {pos_y[PW-1], pos_y} - {origin_y_reg[PW-1], origin_y_reg};
        detw  = heading - origin_heading_reg;
        rot_a = 32'd0 - {origin_heading_reg, 16'd0};
        flip  = (rot_a > 32'h4000_0000) && (rot_a < 32'hC000_0000);
        xs    = {{2{ex[PW]}}, ex, 8'd0};
        ys    = {{2{ey[PW]}}, ey, 8'd0};
        rv[0] = in_valid;
        rx[0] = flip ? -xs : xs;
        ry[0] = flip ? -ys : ys;
        rz[0] = flip ? rot_a + 32'h8000_0000 : rot_a;
        rs[0] = {goal_dx, goal_dy, detw};
    end

    assign in_stall = !rrdy[0];

    for (genvar i = 0; i < NR; i++)
    begin : g_rot
        pesd_cordic_cell #(
            .W(RW), .SW(RSW), .STAGE(i), .VECTORING(1'b0)
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(rv[i]), .in_ready(rrdy[i]),
            .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]), .side_in(rs[i]),
            .out_valid(rv[i+1]), .out_ready(rrdy[i+1]),
            .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1]), .side_out(rs[i+1])
        );
    end

    // gain multiply
    logic                 g_valid_reg;
    logic                 g_ready;
    logic signed [GW-1:0] gx_reg, gy_reg;
    logic [RSW-1:0]       gs_reg;
    logic                 h_ready;

    assign g_ready  = !g_valid_reg || h_ready;
    assign rrdy[NR] = g_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (g_ready)
            g_valid_reg <= rv[NR];
    end

    always_ff @(posedge clk)
    begin
        if (g_ready && rv[NR])
        begin
            gx_reg <= GW'(rx[NR]) * GW'(signed'(21'(INV_GAIN)));
            gy_reg <= GW'(ry[NR]) * GW'(signed'(21'(INV_GAIN)));
            gs_reg <= rs[NR];
        end
    end

    // round and form the remaining vector
    logic                  h_valid_reg;
    logic signed [VXW-1:0] hx_reg, hy_reg;
    logic [ANGLE_W-1:0]    hd_reg;
    logic signed [GW-1:0]  gxr, gyr;
    logic signed [PW-1:0]  gdx, gdy;
    logic                  v_ready;

    assign h_ready = !h_valid_reg || v_ready;

    always_comb
    begin
        gxr = (gx_reg + (GW'(1) <<< 27)) >>> 28;
        gyr = (gy_reg + (GW'(1) <<< 27)) >>> 28;
        gdx = gs_reg[RSW-1 -: PW];
        gdy = gs_reg[RSW-PW-1 -: PW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (h_ready)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (h_ready && g_valid_reg)
        begin
            hx_reg <= VXW'(gdx) - gxr[VXW-1:0];
            hy_reg <= VXW'(gdy) - gyr[VXW-1:0];
            hd_reg <= gs_reg[ANGLE_W-1:0];
        end
    end

    // bearing row
    logic                  vv   [0:NR];
    logic                  vrdy [0:NR];
    logic signed [VW-1:0]  vx   [0:NR];
    logic signed [VW-1:0]  vy   [0:NR];
    logic [CORDIC_Z_W-1:0] vz   [0:NR];
    logic [VSW-1:0]        vs   [0:NR];

    logic                  special;
    logic [ANGLE_W-1:0]    sbear;
    logic [AW-1:0]         abs_x, abs_y;
    logic                  arr;
    logic signed [VW-1:0]  hxs, hys;

    always_comb
    begin
        special = 1'b0;
        sbear   = '0;
        if (hy_reg == '0)
        begin
            special = 1'b1;
            sbear   = hx_reg[VXW-1] ? 16'h8000 : 16'h0000;
        end
        else if (hx_reg == '0)
        begin
            special = 1'b1;
            sbear   = hy_reg[VXW-1] ? 16'hC000 : 16'h4000;
        end
        abs_x = AW'(hx_reg[VXW-1] ? -hx_reg : hx_reg);
        abs_y = AW'(hy_reg[VXW-1] ? -hy_reg : hy_reg);
        arr   = (abs_x < AW'(arrive_tol_reg)) && (abs_y < AW'(arrive_tol_reg));
        hxs   = {{2{hx_reg[VXW-1]}}, hx_reg, 8'd0};
        hys   = {{2{hy_reg[VXW-1]}}, hy_reg, 8'd0};
        vv[0] = h_valid_reg;
        vx[0] = hx_reg[VXW-1] ? -hxs : hxs;
        vy[0] = hx_reg[VXW-1] ? -hys : hys;
        vz[0] = hx_reg[VXW-1] ? 32'h8000_0000 : 32'd0;
        vs[0] = {hd_reg, arr, special, sbear};
    end

    assign v_ready = vrdy[0];

    for (genvar i = 0; i < NR; i++)
    begin : g_vec
        pesd_cordic_cell #(
            .W(VW), .SW(VSW), .STAGE(i), .VECTORING(1'b1)
        ) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(vv[i]), .in_ready(vrdy[i]),
            .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]), .side_in(vs[i]),
            .out_valid(vv[i+1]), .out_ready(vrdy[i+1]),
            .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]), .side_out(vs[i+1])
        );
    end

    // decision and output word
    logic                      o_valid_reg;
    logic                      o_ready;
    logic signed [15:0]        drive_reg, drive_next;
    logic signed [15:0]        turn_reg, turn_next;
    logic                      rev_reg, rev_next;
    logic                      arr_reg;
    logic [CORDIC_Z_W-1:0]     zr;
    logic [ANGLE_W-1:0]        bear, err;
    logic signed [ANGLE_W-1:0] ferr, rerr, chosen;
    logic [ANGLE_W:0]          af, ar, ac;

    assign o_ready  = !o_valid_reg || !out_stall;
    assign vrdy[NR] = o_ready;

    always_comb
    begin
        zr     = vz[NR] + 32'h0000_8000;
        bear   = vs[NR][ANGLE_W] ? vs[NR][ANGLE_W-1:0] : zr[31:16];
        err    = vs[NR][VSW-1 -: ANGLE_W] - bear;
        ferr   = err;
        rerr   = err ^ 16'h8000;
        af     = ferr[15] ? 17'd0 - {ferr[15], ferr} : {1'b0, ferr};
        ar     = rerr[15] ? 17'd0 - {rerr[15], rerr} : {1'b0, rerr};
        rev_next = !(af < ar);
        chosen = rev_next ? rerr : ferr;
        ac     = rev_next ? ar : af;
        drive_next = '0;
        turn_next  = '0;
        if (ac > {2'b00, heading_tol_reg})
            turn_next = chosen[15] ? {1'b0, turn_rate_reg} : 16'd0 - {1'b0, turn_rate_reg};
        else
            drive_next = rev_next ? 16'd0 - {1'b0, drive_speed_reg}
                                  : {1'b0, drive_speed_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= vv[NR];
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && vv[NR])
        begin
            drive_reg <= drive_next;
            turn_reg  <= turn_next;
            rev_reg   <= rev_next;
            arr_reg   <= vs[NR][ANGLE_W+1];
        end
    end

    assign out_valid = o_valid_reg;
    assign drive_cmd = drive_reg;
    assign turn_cmd  = turn_reg;
    assign reversing = rev_reg;
    assign arrived   = arr_reg;

endmodule

// ===== rtl/pesd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesd_checker
// Port-level checks on the steering decision block.
// ----------------------------------------------------------------------------
module pesd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] drive_cmd,
    input logic [15:0] turn_cmd,
    input logic        reversing,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_cmd) && $stable(turn_cmd))
        else $error("stalled output word changed");

    a_drive_or_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_cmd == 16'd0) || (turn_cmd == 16'd0))
        else $error("drive and turn both active");

    a_reverse_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (drive_cmd != 16'd0) |-> drive_cmd[15] == reversing)
        else $error("drive sign disagrees with reversing");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind pose_error_steering_decision_top pesd_checker u_pesd_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .drive_cmd(drive_cmd), .turn_cmd(turn_cmd), .reversing(reversing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pose error steering decision block. A table of
// directed words, then constrained-free random words under several settings
// of the frame and tolerance registers, with idle and stall phases on both
// channels; each result is checked against the table or a bit-exact predictor
// ----------------------------------------------------------------------------
module testbench;
    import pesd_pkg::*;

    localparam int PW      = 20;
    localparam int LAT     = 16 * 2 + 3;
    localparam int CYC_MAX = 2000000;

    typedef struct {
        logic signed [PW-1:0] px, py;
        logic signed [15:0]   hd;
        logic signed [PW-1:0] gx, gy;
    } pose_t;

    typedef struct {
        logic signed [15:0] drive, turn;
        logic               rev, arr;
    } steer_t;

    typedef struct {
        pose_t  p;
        bit     fixed;
        steer_t s;
    } row_t;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_stall = 0, cfg_valid = 0;
    logic signed [PW-1:0] pos_x = 0, pos_y = 0, goal_dx = 0, goal_dy = 0;
    logic signed [15:0] heading = 0;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [PW-1:0] cfg_data = 0;
    logic in_stall, out_valid, cfg_ready, reversing, arrived;
    logic signed [15:0] drive_cmd, turn_cmd;

    pose_error_steering_decision_top uut (.*);

    logic signed [PW-1:0] k_ox = 0, k_oy = 0;
    logic [15:0] k_oh = 0;
    logic [14:0] k_htol = 546, k_dspd = 50, k_trate = 819;
    logic [18:0] k_atol = 80;

    steer_t pending_q[$];
    int errors = 0, checked = 0, sent = 0;
    int send_idle = 0, recv_stall = 0, hold_stall = 0;
    longint cycles = 0;

    localparam logic [31:0] ATAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    initial forever #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint fl_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void frame_rotate(inout longint px, inout longint py,
                                         input logic [31:0] a);
        longint x, y, z, dx, dy;
        x = px * 256;
        y = py * 256;
        if (a > 32'h40000000 && a < 32'hC0000000)
        begin
            x = -x;
            y = -y;
            a = a + 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++)
        begin
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN[i];
            end
        end
        px = fl_shr(x * 636752 + (64'sd1 <<< 27), 28);
        py = fl_shr(y * 636752 + (64'sd1 <<< 27), 28);
    endfunction

    function automatic logic [15:0] target_bearing(longint vx, longint vy);
        longint x, y, dx, dy;
        logic [31:0] z;
        z = 0;
        if (vy == 0) return (vx < 0) ? 16'h8000 : 16'h0000;
        if (vx == 0) return (vy > 0) ? 16'h4000 : 16'hC000;
        x = vx * 256;
        y = vy * 256;
        if (x < 0)
        begin
            x = -x; y = -y; z = 32'h80000000;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN[i];
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic steer_t steer_for(pose_t p);
        longint ex, ey, vx, vy, fe, re, ch;
        logic [15:0] dh, b, e;
        logic [31:0] rot;
        steer_t s;
        ex = longint'(p.px) - longint'(k_ox);
        ey = longint'(p.py) - longint'(k_oy);
        dh = p.hd - k_oh;
        rot = 32'd0 - {k_oh, 16'd0};
        frame_rotate(ex, ey, rot);
        vx = longint'(p.gx) - ex;
        vy = longint'(p.gy) - ey;
        b = target_bearing(vx, vy);
        e = dh - b;
        fe = longint'($signed(e));
        re = longint'($signed(e ^ 16'h8000));
        s.rev = !(mag(fe) < mag(re));
        ch = s.rev ? re : fe;
        s.drive = 0;
        s.turn = 0;
        if (mag(ch) > longint'(k_htol))
            s.turn = (ch < 0) ? $signed({1'b0, k_trate}) : -$signed({1'b0, k_trate});
        else
            s.drive = s.rev ? -$signed({1'b0, k_dspd}) : $signed({1'b0, k_dspd});
        s.arr = mag(vx) < longint'(k_atol) && mag(vy) < longint'(k_atol);
        return s;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want, checked);
    endtask

    // receiver and checker
    always @(posedge clk)
    begin
        steer_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                w = pending_q.pop_front();
                if (drive_cmd !== w.drive) report("drive_cmd", drive_cmd, w.drive);
                if (turn_cmd !== w.turn) report("turn_cmd", turn_cmd, w.turn);
                if (reversing !== w.rev) report("reversing", reversing, w.rev);
                if (arrived !== w.arr) report("arrived", arrived, w.arr);
            end
            checked++;
        end
        if (hold_stall > 0)
        begin
            hold_stall <= hold_stall - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic write_reg(cfg_index_t idx, logic [PW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_ORIGIN_X:       k_ox = val;
            REG_ORIGIN_Y:       k_oy = val;
            REG_ORIGIN_HEADING: k_oh = val[15:0];
            REG_HEADING_TOL:    k_htol = val[14:0];
            REG_ARRIVE_TOL:     k_atol = val[18:0];
            REG_DRIVE_SPEED:    k_dspd = val[14:0];
            default:            k_trate = val[14:0];
        endcase
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    // offer one word; queue the expectation on acceptance
    task automatic send(pose_t p, bit fixed, steer_t s);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1;
        pos_x <= p.px; pos_y <= p.py; heading <= p.hd;
        goal_dx <= p.gx; goal_dy <= p.gy;
        do @(posedge clk); while (in_stall);
        pending_q.push_back(fixed ? s : steer_for(p));
        sent++;
    endtask

    function automatic logic signed [PW-1:0] rpos();
        case ($urandom_range(3))
            0: return $signed(PW'($urandom));
            1: return $signed(PW'($urandom_range(400))) - 200;
            2: return $urandom_range(1) ? 20'sh7FFFF : 20'sh80000;
            default: return $signed(PW'($urandom_range(8000))) - 4000;
        endcase
    endfunction

    function automatic pose_t rpose();
        pose_t p;
        p.px = rpos(); p.py = rpos(); p.gx = rpos(); p.gy = rpos();
        p.hd = $urandom;
        if ($urandom_range(5) == 0) p.gy = p.py;
        if ($urandom_range(5) == 0) p.gx = p.px;
        return p;
    endfunction

    task automatic random_phase(int n, int si, int rs);
        send_idle = si;
        recv_stall = rs;
        repeat (n) send(rpose(), 0, '{0, 0, 0, 0});
    endtask

    row_t dir_tab[$];

    initial
    begin
        steer_t none;
        none = '{0, 0, 0, 0};
        // zero vector, reset settings: bearing 0, heading on it drives forward
        dir_tab.push_back('{'{0, 0, 0, 0, 0}, 1, '{16'sd50, 0, 0, 1}});
        dir_tab.push_back('{'{0, 0, 16'sh4000, 0, 0}, 0, none});
        dir_tab.push_back('{'{0, 0, 16'sh8000, 0, 0}, 1, '{-16'sd50, 0, 1, 1}});
        dir_tab.push_back('{'{0, 0, 16'sd546, 0, 0}, 1, '{16'sd50, 0, 0, 1}});
        dir_tab.push_back('{'{0, 0, 16'sd547, 0, 0}, 1, '{0, -16'sd819, 0, 1}});
        dir_tab.push_back('{'{0, 0, -16'sd547, 0, 0}, 1, '{0, 16'sd819, 0, 1}});
        dir_tab.push_back('{'{0, 0, 0, -20'sd500, 0}, 0, none});
        dir_tab.push_back('{'{0, 0, 0, 20'sd500, 0}, 0, none});
        dir_tab.push_back('{'{0, 0, 0, 0, 20'sd500}, 0, none});
        dir_tab.push_back('{'{0, 0, 0, 0, -20'sd500}, 0, none});
        dir_tab.push_back('{'{20'sh7FFFF, 20'sh7FFFF, 16'sh7FFF, 20'sh80000, 20'sh80000}, 0, none});
        dir_tab.push_back('{'{20'sh80000, 20'sh80000, 16'sh8000, 20'sh7FFFF, 20'sh7FFFF}, 0, none});
        dir_tab.push_back('{'{20'sd79, 0, 0, 20'sd79, 20'sd79}, 0, none});
        dir_tab.push_back('{'{0, 0, 0, 20'sd79, -20'sd79}, 0, none});
        dir_tab.push_back('{'{0, 0, 0, 20'sd80, 0}, 0, none});
        dir_tab.push_back('{'{-20'sd1, -20'sd1, -16'sd1, 20'sd1, 20'sd1}, 0, none});

        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir_tab[i]) send(dir_tab[i].p, dir_tab[i].fixed, dir_tab[i].s);
        drain();

        // origin heading beyond a right angle, then extremes of every register
        write_reg(REG_ORIGIN_HEADING, 20'h08000);
        write_reg(REG_ORIGIN_X, 20'h00100);
        write_reg(REG_ORIGIN_Y, 20'hFFF00);
        for (int i = 0; i < 8; i++) send(dir_tab[i].p, 0, none);
        random_phase(200, 0, 0);
        drain();

        write_reg(REG_ORIGIN_X, 20'h7FFFF);
        write_reg(REG_ORIGIN_Y, 20'h80000);
        write_reg(REG_ORIGIN_HEADING, 20'h0C001);
        write_reg(REG_HEADING_TOL, 20'h07FFF);
        write_reg(REG_ARRIVE_TOL, 20'h7FFFF);
        write_reg(REG_DRIVE_SPEED, 20'h07FFF);
        write_reg(REG_TURN_RATE, 20'h07FFF);
        random_phase(200, 72, 0);
        drain();

        write_reg(REG_ORIGIN_X, 20'h80000);
        write_reg(REG_ORIGIN_Y, 20'h7FFFF);
        write_reg(REG_ORIGIN_HEADING, 20'h07FFF);
        write_reg(REG_HEADING_TOL, 20'h0);
        write_reg(REG_ARRIVE_TOL, 20'h0);
        write_reg(REG_DRIVE_SPEED, 20'h0);
        write_reg(REG_TURN_RATE, 20'h0);
        random_phase(200, 0, 72);
        drain();

        write_reg(REG_ORIGIN_X, PW'($urandom_range(2000)) - 20'd1000);
        write_reg(REG_ORIGIN_Y, PW'($urandom_range(2000)) - 20'd1000);
        write_reg(REG_ORIGIN_HEADING, PW'($urandom_range(65535)));
        write_reg(REG_HEADING_TOL, 20'd3000);
        write_reg(REG_ARRIVE_TOL, 20'd4000);
        write_reg(REG_DRIVE_SPEED, 20'd1234);
        write_reg(REG_TURN_RATE, 20'd4321);
        random_phase(200, 19, 19);
        // hold the receiver off so the pipeline fills and stalls its input
        hold_stall = 300;
        random_phase(150, 0, 0);
        drain();
        random_phase(250, 0, 0);
        random_phase(200, 72, 72);
        drain();

        $display("ran %0d words through %0d results across five register settings", sent,
                 checked);
        $display("idle and stall phases on both channels plus a long receiver hold");
        if (errors == 0 && pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== pose_error_steering_decision_top.f =====
rtl/pesd_pkg.sv
rtl/pesd_cordic_cell.sv
rtl/pose_error_steering_decision_top.sv
rtl/pesd_checker.sv
sim/testbench.sv
